### rtl/wgn_pkg.sv
// ----------------------------------------------------------------------------
// wgn_pkg
// shared types and constants of the walkability grid neighbor core
// ----------------------------------------------------------------------------
`default_nettype none

package wgn_pkg;

  // field and register widths
  localparam int GRID_W  = 7;
  localparam int DIAG_W  = 2;
  localparam int AREA_W  = 2 * GRID_W;
  localparam int CNT_W   = 13;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;
  localparam logic [CNT_W-1:0]  CNT_SAT    = '1;

  // item opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // diagonal modes
  localparam logic [DIAG_W-1:0] DIAG_NEVER  = 2'd0;
  localparam logic [DIAG_W-1:0] DIAG_ALWAYS = 2'd1;
  localparam logic [DIAG_W-1:0] DIAG_EITHER = 2'd2;
  localparam logic [DIAG_W-1:0] DIAG_BOTH   = 2'd3;

  // register indexes (word address)
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DIAG_MODE   = 2'd2;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [GRID_W-1:0] used_w;
    logic [GRID_W-1:0] used_h;
    logic [DIAG_W-1:0] diag_mode;
    logic [AREA_W-1:0] area;
    logic              map_clear;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/walkability_grid_neighbors_core.sv
// ----------------------------------------------------------------------------
// walkability_grid_neighbors_core
// walkable-cell bit map with write, read and 8-connected neighbor query
// ----------------------------------------------------------------------------
// The map holds one row of MAX_WIDTH walkable bits per memory entry in a
// single-port-read, single-port-write synchronous memory. Each item works on
// one cell: a write or read fetches the cell's row once (read, then write
// back on the evaluate cycle); a neighbor query fetches the rows above, at
// and below the cell, one a cycle through the one read port. The next item
// is accepted only once the evaluate step is done. The result sits in an
// output register, so a new item is taken while a result waits, and the
// core only holds its evaluate step while the previous result is still
// untaken. After reset, and on any write of grid_width or grid_height, every
// cell reads walkable at once (per-row valid bits) and the blocked count is
// zero; no clearing pass is needed. Positions outside the configured area
// read as not walkable, and writes there are dropped. walkable_count is the
// area minus blocked cells, saturating at 8191.
// ----------------------------------------------------------------------------
`default_nettype none

module walkability_grid_neighbors_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wgn_pkg::PADDR_W-1:0]  paddr,
  input  logic [wgn_pkg::PDATA_W-1:0]  pwdata,
  output logic [wgn_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // item channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic signed [7:0]            x_pos_i,
  input  logic signed [7:0]            y_pos_i,
  input  logic                         write_value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o,
  output logic                         cell_walkable_o,
  output logic [7:0]                   neighbor_mask_o,
  output logic [wgn_pkg::CNT_W-1:0]    walkable_count_o
);
  import wgn_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  cfg_t cfg;

  state_e          state_q;
  logic [1:0]      op_q;
  logic [7:0]      x_q, y_q;
  logic            wv_q;
  logic [1:0]      phase_q, cap_k_q;
  logic            cap_vld_q;
  logic [2:0][2:0] win_q;
  logic [AREA_W-1:0] blk_q;

  logic            out_valid_q, inside_q, cell_q;
  logic [7:0]      mask_q;
  logic [CNT_W-1:0] count_q;

  // ---- window geometry ----------------------------------------------------
  logic [2:0][8:0] xc, yc;
  logic [2:0]      col_in, row_in;
  logic [8:0]      yi;
  logic            iss_in;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // neighbor columns and rows, 9-bit two's complement
      xc[c] = {x_q[7], x_q} + 9'(c) - 9'd1;
      yc[c] = {y_q[7], y_q} + 9'(c) - 9'd1;
      col_in[c] = !xc[c][8] && (xc[c][7:0] < {1'b0, cfg.used_w});
      row_in[c] = !yc[c][8] && (yc[c][7:0] < {1'b0, cfg.used_h});
    end
  end

  // row fetched in this read cycle: phase 0 above, 1 at, 2 below
  assign yi     = {y_q[7], y_q} + {7'd0, phase_q} - 9'd1;
  assign iss_in = !yi[8] && (yi[7:0] < {1'b0, cfg.used_h});

  // ---- map memory ---------------------------------------------------------
  logic                 rd_en, wr_en;
  logic [MAX_WIDTH-1:0] rd_row, wr_row;
  logic [COL_W-1:0]     x_idx;

  assign rd_en = (state_q == ST_READ) && iss_in;
  assign x_idx = COL_W'(x_q);

  wgn_row_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ROW_W      (ROW_W)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg.map_clear),
    .rd_en_i   (rd_en),
    .rd_addr_i (ROW_W'(yi[7:0])),
    .rd_data_o (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (ROW_W'(y_q)),
    .wr_data_i (wr_row)
  );

  // ---- capture of the three bits around x from each fetched row -----------
  logic [2:0]      rd_bits;
  logic [2:0][2:0] win_now, win_eff;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rd_bits[c] = col_in[c] & rd_row[COL_W'(xc[c][7:0])];
    end
    win_now = win_q;
    // row arriving this cycle bypasses the window registers
    if (cap_vld_q) begin
      win_now[cap_k_q] = rd_bits;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_eff[r][c] = row_in[r] & col_in[c] & win_now[r][c];
      end
    end
  end

  logic [7:0] mask_raw;

  wgn_nbr_eval u_nbr_eval (
    .win_i       (win_eff),
    .diag_mode_i (cfg.diag_mode),
    .mask_o      (mask_raw)
  );

  // ---- evaluate step ------------------------------------------------------
  logic              pos_in, is_write, is_query, proceed, old_bit, cell_new;
  logic [1:0]        phase_last;
  logic [AREA_W-1:0] blk_d, cnt_full;
  logic [CNT_W-1:0]  cnt_sat;

  assign pos_in     = row_in[1] & col_in[1];
  assign is_write   = (op_q == OP_WRITE);
  assign is_query   = (op_q == OP_QUERY);
  assign phase_last = is_query ? 2'd2 : 2'd1;
  assign proceed    = !out_valid_q || out_ready_i;
  assign old_bit    = rd_row[x_idx];
  assign wr_en      = (state_q == ST_EVAL) && proceed && is_write && pos_in;

  always_comb begin
    wr_row        = rd_row;
    wr_row[x_idx] = wv_q;
  end

  always_comb begin
    blk_d = blk_q;
    if (wr_en && (old_bit != wv_q)) begin
      blk_d = wv_q ? (blk_q - AREA_W'(1)) : (blk_q + AREA_W'(1));
    end
  end

  assign cnt_full = (cfg.area > blk_d) ? (cfg.area - blk_d) : '0;
  assign cnt_sat  = (cnt_full > AREA_W'(CNT_SAT)) ? CNT_SAT : cnt_full[CNT_W-1:0];
  assign cell_new = is_write ? (pos_in & wv_q) : win_eff[1][1];

  // ---- sequencer ----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_READ;
      x_q         <= '0;
      y_q         <= '0;
      wv_q        <= 1'b0;
      phase_q     <= '0;
      cap_k_q     <= '0;
      cap_vld_q   <= 1'b0;
      win_q       <= '0;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
      cell_q      <= 1'b0;
      mask_q      <= '0;
      count_q     <= '0;
    end else begin
      cap_vld_q   <= (state_q == ST_READ);
      win_q       <= win_now;
      out_valid_q <= ((state_q == ST_EVAL) && proceed) || (out_valid_q && !out_ready_i);
      // size change empties the blocked set
      blk_q       <= cfg.map_clear ? '0 : blk_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            x_q     <= x_pos_i;
            y_q     <= y_pos_i;
            wv_q    <= write_value_i;
            // a query fetches three rows, everything else only its own
            phase_q <= (opcode_i == OP_QUERY) ? 2'd0 : 2'd1;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          cap_k_q <= phase_q;
          if (phase_q == phase_last) begin
            state_q <= ST_EVAL;
          end else begin
            phase_q <= phase_q + 2'd1;
          end
        end
        ST_EVAL: begin
          if (proceed) begin
            inside_q <= pos_in;
            cell_q   <= cell_new;
            mask_q   <= is_query ? mask_raw : 8'd0;
            count_q  <= cnt_sat;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign inside_res_o     = inside_q;
  assign cell_walkable_o  = cell_q;
  assign neighbor_mask_o  = mask_q;
  assign walkable_count_o = count_q;

  // ---- configuration ------------------------------------------------------
  wgn_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

endmodule

`default_nettype wire

### rtl/wgn_cfg_regs.sv
// ----------------------------------------------------------------------------
// wgn_cfg_regs
// apb register file: grid size and diagonal mode, clamped size and area
// ----------------------------------------------------------------------------
`default_nettype none

module wgn_cfg_regs #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wgn_pkg::PADDR_W-1:0]  paddr,
  input  logic [wgn_pkg::PDATA_W-1:0]  pwdata,
  output logic [wgn_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output wgn_pkg::cfg_t                cfg_o
);
  import wgn_pkg::*;

  logic [GRID_W-1:0] grid_width_q, grid_height_q;
  logic [DIAG_W-1:0] diag_mode_q;
  logic [AREA_W-1:0] area_q;
  logic              wr_acc;
  logic [1:0]        reg_idx;
  logic [GRID_W-1:0] used_w, used_h;

  assign pready  = 1'b1;
  assign wr_acc  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_RESET;
      grid_height_q <= GRID_RESET;
      diag_mode_q   <= DIAG_NEVER;
    end else if (wr_acc) begin
      case (reg_idx)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[GRID_W-1:0];
        REG_DIAG_MODE:   diag_mode_q   <= pwdata[DIAG_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes above the map clamp to the map
  assign used_w = (32'(grid_width_q) > MAX_WIDTH) ? GRID_W'(MAX_WIDTH) : grid_width_q;
  assign used_h = (32'(grid_height_q) > MAX_HEIGHT) ? GRID_W'(MAX_HEIGHT) : grid_height_q;

  always_ff @(posedge clk_i) begin
    area_q <= AREA_W'(used_w) * AREA_W'(used_h);
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_q);
      REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_q);
      REG_DIAG_MODE:   prdata = PDATA_W'(diag_mode_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.used_w    = used_w;
  assign cfg_o.used_h    = used_h;
  assign cfg_o.diag_mode = diag_mode_q;
  assign cfg_o.area      = area_q;
  assign cfg_o.map_clear = wr_acc & ((reg_idx == REG_GRID_WIDTH) |
                                     (reg_idx == REG_GRID_HEIGHT));

endmodule

`default_nettype wire

### rtl/wgn_row_mem.sv
// ----------------------------------------------------------------------------
// wgn_row_mem
// one row per entry map memory, registered read, row valid bits for clearing
// ----------------------------------------------------------------------------
`default_nettype none

module wgn_row_mem #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int ROW_W      = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 rd_en_i,
  input  logic [ROW_W-1:0]     rd_addr_i,
  output logic [MAX_WIDTH-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [ROW_W-1:0]     wr_addr_i,
  input  logic [MAX_WIDTH-1:0] wr_data_i
);

  logic [MAX_WIDTH-1:0]  mem_q [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld_q;
  logic [MAX_WIDTH-1:0]  rd_data_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // a row never written since the last clear reads as all walkable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        row_vld_q <= '0;
      end else if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '1;

endmodule

`default_nettype wire

### rtl/wgn_nbr_eval.sv
// ----------------------------------------------------------------------------
// wgn_nbr_eval
// 3x3 walkable window to 8-bit neighbor mask under the diagonal mode
// ----------------------------------------------------------------------------
`default_nettype none

module wgn_nbr_eval (
  input  logic [2:0][2:0]               win_i,
  input  logic [wgn_pkg::DIAG_W-1:0]    diag_mode_i,
  output logic [7:0]                    mask_o
);
  import wgn_pkg::*;

  // win_i[row][col], row 0 above, col 0 left
  logic [7:0] w;
  logic [3:0] diag_ok;
  logic [3:0] orth_a, orth_b;

  assign w[0] = win_i[0][1];  // up
  assign w[1] = win_i[1][2];  // right
  assign w[2] = win_i[2][1];  // down
  assign w[3] = win_i[1][0];  // left
  assign w[4] = win_i[0][0];  // upleft
  assign w[5] = win_i[0][2];  // upright
  assign w[6] = win_i[2][2];  // downright
  assign w[7] = win_i[2][0];  // downleft

  // orthogonals flanking each diagonal
  assign orth_a = {w[2], w[1], w[0], w[3]};
  assign orth_b = w[3:0];

  always_comb begin
    case (diag_mode_i)
      DIAG_ALWAYS: diag_ok = '1;
      DIAG_EITHER: diag_ok = orth_a | orth_b;
      DIAG_BOTH:   diag_ok = orth_a & orth_b;
      default:     diag_ok = '0;
    endcase
  end

  assign mask_o = {w[7:4] & diag_ok, w[3:0]};

endmodule

`default_nettype wire
